[hdl/scsa_pkg.sv]
// scsa_pkg: types and constants for the size class slab allocator
// no dependencies
package scsa_pkg;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StTooLarge = 2'd1;
  localparam logic [1:0] StNoPool   = 2'd2;
  localparam logic [1:0] StBadFree  = 2'd3;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  localparam int unsigned CoarseCount = 5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_READ,
    S_EXEC,
    S_LINK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] req_size;
    logic [23:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [23:0] block_addr;
    logic [1:0]  status;
  } rsp_t;

  function automatic logic [17:0] coarse_size(input logic [2:0] i);
    logic [17:0] r;
    begin
      case (i)
        3'd0:    r = 18'd8192;
        3'd1:    r = 18'd16384;
        3'd2:    r = 18'd32768;
        3'd3:    r = 18'd65536;
        default: r = 18'd131072;
      endcase
      return r;
    end
  endfunction

endpackage

[hdl/scsa_if.sv]
// scsa_if: valid/ready channel carrying one payload
// depends on nothing; payload type given as a parameter
interface scsa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/size_class_slab_allocator.sv]
// size_class_slab_allocator: segregated size-class slab allocator over a fixed chunk pool
// sequence: head read, memory read, exec (a free waits there on a serial block divide), link, done
// one request at a time: the next is taken in idle only after the response is taken and fixups are done
// reset clears the claim count, then a clearing pass sets all 261 class list heads to null
// with the request input held not ready; headers and links need no reset
// depends on scsa_pkg and scsa_if
module size_class_slab_allocator
  import scsa_pkg::*;
#(
  parameter int unsigned NUM_CHUNKS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  scsa_if.sink   req_i,
  scsa_if.source rsp_o
);

  localparam int unsigned ChunkLog2   = 20;
  localparam int unsigned HeaderBytes = 64;
  localparam int unsigned FineClasses = 256;
  localparam int unsigned NumClasses  = FineClasses + CoarseCount;
  localparam int unsigned CW          = $clog2(NUM_CHUNKS + 1);
  localparam int unsigned IW          = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned SlotLog2    = 16;
  localparam logic [CW-1:0] Nil       = CW'(NUM_CHUNKS);

  typedef struct packed {
    logic [8:0]    cls;
    logic [20:0]   bump;
    logic [16:0]   live;
    logic [15:0]   fhead;
    logic          full;
    logic [CW-1:0] prev;
    logic [CW-1:0] next;
  } hdr_t;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_v_q;
  logic [CW-1:0] claimed_q;
  logic [8:0]    clr_q;

  hdr_t hdr_mem [NUM_CHUNKS];
  logic [15:0] link_mem [NUM_CHUNKS << SlotLog2];
  logic [CW-1:0] ahd_mem [NumClasses];
  hdr_t hdr_rd_q;
  logic [15:0] link_rd_q;
  logic [CW-1:0] ahd_rd_q;

  // decode
  logic [8:0]  cls;
  logic        too_large;
  logic [17:0] blk;
  logic [31:0] sz;
  always_comb begin
    sz = req_q.req_size;
    too_large = 1'b0;
    cls = '0;
    if (sz <= 32'd4096) begin
      cls = (sz == 0) ? 9'd0 : 9'((sz - 32'd1) >> 4);
    end else if (sz <= 32'd8192) cls = 9'd256;
    else if (sz <= 32'd16384) cls = 9'd257;
    else if (sz <= 32'd32768) cls = 9'd258;
    else if (sz <= 32'd65536) cls = 9'd259;
    else if (sz <= 32'd131072) cls = 9'd260;
    else too_large = 1'b1;
  end

  // all chunk fields seen by the step; free uses its chunk header class
  logic [CW-1:0] fc;
  logic [8:0]    ucls;
  assign fc = CW'(req_q.free_addr >> ChunkLog2);
  assign ucls = (req_q.req_type == ReqFree) ? hdr_rd_q.cls : cls;
  always_comb begin
    if (ucls < 9'(FineClasses)) blk = 18'((ucls + 9'd1)) << 4;
    else blk = coarse_size(3'(ucls - 9'(FineClasses)));
  end

  logic [CW-1:0] cur_c;
  logic          need_claim;
  assign need_claim = (req_q.req_type == ReqAlloc) && (ahd_rd_q == Nil);
  assign cur_c = (req_q.req_type == ReqFree) ? fc :
                 (need_claim ? claimed_q : ahd_rd_q);

  // linked neighbour fixups are done on the small header array as a
  // read then a single-entry write, through a queue of up to two
  hdr_t h;
  logic [20:0] off;
  logic [20:0] roff;
  assign off = 21'(req_q.free_addr[19:0]);

  // free checks
  logic [20:0] rel;
  logic [17:0] rem;
  logic [15:0] nblk;
  always_comb begin
    rel = off - 21'(HeaderBytes);
    case (blk)
      18'd8192:   begin rem = 18'(rel[12:0]);  nblk = 16'(rel >> 13); end
      18'd16384:  begin rem = 18'(rel[13:0]);  nblk = 16'(rel >> 14); end
      18'd32768:  begin rem = 18'(rel[14:0]);  nblk = 16'(rel >> 15); end
      18'd65536:  begin rem = 18'(rel[15:0]);  nblk = 16'(rel >> 16); end
      18'd131072: begin rem = 18'(rel[16:0]);  nblk = 16'(rel >> 17); end
      default:    begin rem = '0;              nblk = '0;             end
    endcase
  end
  // fine class division is done by an iterative divider
  logic [20:0] dv_rem_q;
  logic [15:0] dv_quo_q;
  logic [4:0]  dv_cnt_q;
  logic        dv_busy_q;
  logic        fine_free;
  assign fine_free = hdr_rd_q.cls < 9'(FineClasses);

  // header write queue for neighbour updates
  logic          nb_we_q [2];
  logic [IW-1:0] nb_idx_q [2];
  logic          nb_setp_q [2];
  logic [CW-1:0] nb_val_q [2];
  logic          nb_rd_q;
  logic          nb_sel_q;
  hdr_t          nbh;

  logic          hw_we;
  logic [IW-1:0] hw_idx;
  hdr_t          hw_dat;
  logic          lw_we;
  logic [IW+SlotLog2-1:0] l_addr;
  logic [15:0]   lw_dat;
  logic [8:0]    ahd_raddr;
  logic          ahd_we;
  logic [8:0]    ahd_waddr;
  logic [CW-1:0] ahd_wdat;

  logic [IW-1:0] rd_idx;
  logic          nb_pend;
  assign nb_pend = nb_we_q[0] | nb_we_q[1];

  assign req_i.ready = (state_q == S_IDLE) && !rsp_v_q && !nb_pend;
  assign rsp_o.valid = rsp_v_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == 9'(NumClasses - 1)) state_d = S_IDLE;
      S_IDLE: if (req_i.valid && req_i.ready) state_d = S_HEAD;
      S_HEAD: state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: if (!dv_busy_q) state_d = S_LINK;
      S_LINK: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // header, link and list head memories: one read port, one write port each
  always_ff @(posedge clk_i) begin
    hdr_rd_q <= hdr_mem[rd_idx];
    if (hw_we) hdr_mem[hw_idx] <= hw_dat;
    else if (nb_rd_q) hdr_mem[nb_idx_q[nb_sel_q]] <= nbh;
    link_rd_q <= link_mem[l_addr];
    if (lw_we) link_mem[l_addr] <= lw_dat;
    ahd_rd_q <= ahd_mem[ahd_raddr];
    if (ahd_we) ahd_mem[ahd_waddr] <= ahd_wdat;
  end

  // main control and datapath
  logic [15:0] n_d;
  logic        bad;
  logic        fullc;
  logic        go_exec;
  logic [23:0] oaddr;
  always_comb begin
    rd_idx = IW'(cur_c);
    hw_we = 1'b0; hw_idx = IW'(cur_c); hw_dat = hdr_rd_q;
    lw_we = 1'b0; lw_dat = '0;
    l_addr = {IW'(cur_c), hdr_rd_q.fhead};
    ahd_raddr = (state_q == S_EXEC) ? ucls : cls;
    ahd_we = 1'b0; ahd_waddr = cls; ahd_wdat = Nil;
    rsp_d = rsp_q;
    h = hdr_rd_q;
    bad = 1'b0; fullc = 1'b0; oaddr = '0; roff = '0; n_d = '0;
    go_exec = (state_q == S_LINK);
    if (state_q == S_CLEAR) begin
      ahd_we = 1'b1;
      ahd_waddr = clr_q;
    end
    if (need_claim) begin
      h.cls = cls; h.bump = 21'(HeaderBytes); h.live = '0; h.fhead = '0;
      h.full = 1'b0; h.prev = Nil; h.next = Nil;
    end
    if (state_q == S_EXEC) begin
      l_addr = {IW'(cur_c), hdr_rd_q.fhead};
    end
    if (go_exec) begin
      if (req_q.req_type == ReqAlloc) begin
        if (too_large) rsp_d = '{24'd0, StTooLarge};
        else if (need_claim && claimed_q >= CW'(NUM_CHUNKS))
          rsp_d = '{24'd0, StNoPool};
        else begin
          if (h.fhead != 0) begin
            roff = 21'(HeaderBytes) + 21'(32'(h.fhead - 16'd1) * 32'(blk));
            h.fhead = link_rd_q;
          end else begin
            roff = h.bump;
            h.bump = h.bump + 21'(blk);
          end
          h.live = h.live + 17'd1;
          if (h.fhead == 0 && 22'(h.bump) + 22'(blk) > 22'(1 << ChunkLog2)) begin
            fullc = 1'b1; h.full = 1'b1; h.prev = Nil; h.next = Nil;
          end
          if (need_claim) begin
            ahd_we = 1'b1;
            ahd_wdat = fullc ? Nil : cur_c;
          end else if (fullc && hdr_rd_q.prev == Nil) begin
            ahd_we = 1'b1;
            ahd_wdat = hdr_rd_q.next;
          end
          oaddr = 24'((32'(cur_c) << ChunkLog2) + 32'(roff));
          rsp_d = '{oaddr, StOk};
          hw_we = 1'b1;
        end
      end else begin
        if (req_q.free_addr == 0) rsp_d = '{24'd0, StOk};
        else begin
          bad = (32'(fc) >= 32'(claimed_q)) || (32'(fc) >= NUM_CHUNKS) ||
                (off < 21'(HeaderBytes)) || (off >= h.bump) || (h.live == 0);
          if (!bad) begin
            if (fine_free) begin
              bad = (dv_rem_q != 0);
              n_d = dv_quo_q + 16'd1;
            end else begin
              bad = (rem != 0);
              n_d = nblk + 16'd1;
            end
          end
          if (bad) rsp_d = '{24'd0, StBadFree};
          else begin
            lw_we = 1'b1;
            l_addr = {IW'(fc), n_d};
            lw_dat = h.fhead;
            h.fhead = n_d;
            h.live = h.live - 17'd1;
            if (h.full) begin
              h.full = 1'b0; h.prev = Nil; h.next = ahd_rd_q;
              ahd_we = 1'b1;
              ahd_waddr = hdr_rd_q.cls;
              ahd_wdat = fc;
            end
            hw_we = 1'b1;
            rsp_d = '{24'd0, StOk};
          end
        end
      end
      hw_dat = h;
    end else if (nb_we_q[0]) begin
      rd_idx = nb_idx_q[0];
    end else if (nb_we_q[1]) begin
      rd_idx = nb_idx_q[1];
    end
  end

  // neighbour fixup: read once the step is past link (done or idle), write back next cycle
  always_comb begin
    nbh = hdr_rd_q;
    if (nb_setp_q[nb_sel_q]) nbh.prev = nb_val_q[nb_sel_q];
    else nbh.next = nb_val_q[nb_sel_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rsp_v_q <= 1'b0;
      rsp_q <= '0;
      claimed_q <= '0;
      clr_q <= '0;
      for (int i = 0; i < 2; i++) begin
        nb_we_q[i] <= 1'b0;
        nb_idx_q[i] <= '0;
        nb_setp_q[i] <= 1'b0;
        nb_val_q[i] <= '0;
      end
      nb_rd_q <= 1'b0;
      nb_sel_q <= 1'b0;
      dv_busy_q <= 1'b0;
      dv_rem_q <= '0;
      dv_quo_q <= '0;
      dv_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 9'd1;
      if (rsp_o.valid && rsp_o.ready) rsp_v_q <= 1'b0;
      if (state_q == S_DONE) rsp_v_q <= 1'b1;
      if (go_exec) rsp_q <= rsp_d;
      dv_busy_q <= 1'b0;
      if (state_q == S_READ && req_q.req_type == ReqFree) begin
        dv_busy_q <= 1'b1;
        dv_rem_q <= off - 21'(HeaderBytes);
        dv_quo_q <= '0;
        dv_cnt_q <= 5'd16;
      end
      if (dv_busy_q) begin
        if (dv_cnt_q != 0) begin
          dv_cnt_q <= dv_cnt_q - 5'd1;
          dv_busy_q <= 1'b1;
          if (32'(dv_rem_q) >= (32'(blk) << (dv_cnt_q - 5'd1))) begin
            dv_rem_q <= 21'(32'(dv_rem_q) - (32'(blk) << (dv_cnt_q - 5'd1)));
            dv_quo_q <= dv_quo_q | 16'(32'd1 << (dv_cnt_q - 5'd1));
          end
        end
      end
      if (go_exec && req_q.req_type == ReqAlloc && !too_large &&
          !(need_claim && claimed_q >= CW'(NUM_CHUNKS))) begin
        if (need_claim) claimed_q <= claimed_q + CW'(1);
        if (fullc && !need_claim) begin
          if (hdr_rd_q.prev != Nil) begin
            nb_we_q[0] <= 1'b1; nb_idx_q[0] <= IW'(hdr_rd_q.prev);
            nb_setp_q[0] <= 1'b0; nb_val_q[0] <= hdr_rd_q.next;
          end
          if (hdr_rd_q.next != Nil) begin
            nb_we_q[1] <= 1'b1; nb_idx_q[1] <= IW'(hdr_rd_q.next);
            nb_setp_q[1] <= 1'b1; nb_val_q[1] <= hdr_rd_q.prev;
          end
        end
      end
      if (go_exec && req_q.req_type == ReqFree && req_q.free_addr != 0 && !bad &&
          hdr_rd_q.full) begin
        if (ahd_rd_q != Nil) begin
          nb_we_q[1] <= 1'b1; nb_idx_q[1] <= IW'(ahd_rd_q);
          nb_setp_q[1] <= 1'b1; nb_val_q[1] <= fc;
        end
      end
      nb_rd_q <= 1'b0;
      if (!go_exec && state_q != S_LINK && !nb_rd_q && nb_pend) begin
        nb_rd_q <= 1'b1;
        nb_sel_q <= nb_we_q[0] ? 1'b0 : 1'b1;
      end
      if (nb_rd_q) nb_we_q[nb_sel_q] <= 1'b0;
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid && req_i.ready) req_q <= req_i.data;
  end

endmodule

[hdl/scsa_checker.sv]
// scsa_checker: port-level assertions for the slab allocator
// depends on scsa_pkg; bound to size_class_slab_allocator
module scsa_checker
  import scsa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && !out_ready |=> out_valid && $stable(out_data);
  endproperty
  a_hold: assert property (p_hold) else $error("response dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second request taken while busy");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != StOk |-> out_data.block_addr == 24'd0)
    else $error("address on failed request");

  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("request taken while response waits");
endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready), .out_data(rsp_o.data)
);

[test/size_class_slab_allocator_tb.sv]
// size_class_slab_allocator_tb: checks alloc and free responses of the slab allocator
// against a behavioural allocator model in the bench: directed table, pool fill, random
// depends on scsa_pkg, scsa_if and size_class_slab_allocator
module size_class_slab_allocator_tb;
  import scsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NChunks   = 16;
  localparam int unsigned ChunkLog2 = 20;
  localparam int unsigned ChunkSize = 1 << ChunkLog2;
  localparam int unsigned HdrBytes  = 64;
  localparam int unsigned FineCls   = 256;
  localparam int unsigned NumCls    = FineCls + CoarseCount;
  localparam int unsigned Slots     = ChunkSize / 16;
  localparam int unsigned Nil       = NChunks;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic failed = 1'b0;

  scsa_if #(.T(req_t)) req_if ();
  scsa_if #(.T(rsp_t)) rsp_if ();

  size_class_slab_allocator #(.NUM_CHUNKS(NChunks)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator shadow state
  int unsigned n_claimed;
  int unsigned c_cls[NChunks], c_bump[NChunks], c_live[NChunks], c_fhead[NChunks];
  bit          c_full[NChunks];
  int unsigned c_prev[NChunks], c_next[NChunks];
  int unsigned cls_head[NumCls];
  int unsigned link_mem[int unsigned];

  rsp_t        pending_rsp[$];
  logic [23:0] live_blocks[$];
  bit          no_idle;

  function automatic int unsigned blk_bytes(int unsigned cls);
    if (cls < FineCls) return (cls + 1) * 16;
    return 8192 << (cls - FineCls);
  endfunction

  function automatic int unsigned size_class(logic [31:0] sz);
    if (sz <= 4096) return (sz == 0) ? 0 : (sz + 15) / 16 - 1;
    for (int i = 0; i < CoarseCount; i++)
      if (64'(sz) <= 64'(8192 << i)) return FineCls + i;
    return NumCls;
  endfunction

  function automatic void unlink_chunk(int unsigned cls, int unsigned c);
    int unsigned p, n;
    p = c_prev[c];
    n = c_next[c];
    if (p < NChunks) c_next[p] = n;
    else cls_head[cls] = n;
    if (n < NChunks) c_prev[n] = p;
    c_prev[c] = Nil;
    c_next[c] = Nil;
  endfunction

  function automatic void push_chunk(int unsigned cls, int unsigned c);
    int unsigned h;
    h = cls_head[cls];
    c_prev[c] = Nil;
    c_next[c] = h;
    if (h < NChunks) c_prev[h] = c;
    cls_head[cls] = c;
  endfunction

  function automatic rsp_t alloc_block(logic [31:0] sz);
    rsp_t r;
    int unsigned cls, c, blk, off, n;
    r = '0;
    cls = size_class(sz);
    if (cls >= NumCls) begin
      r.status = StTooLarge;
      return r;
    end
    blk = blk_bytes(cls);
    c = cls_head[cls];
    if (c >= NChunks) begin
      if (n_claimed >= NChunks) begin
        r.status = StNoPool;
        return r;
      end
      c = n_claimed++;
      c_cls[c] = cls;
      c_bump[c] = HdrBytes;
      c_live[c] = 0;
      c_fhead[c] = 0;
      c_full[c] = 0;
      push_chunk(cls, c);
    end
    if (c_fhead[c] != 0) begin
      n = c_fhead[c] % Slots;
      off = HdrBytes + (n - 1) * blk;
      c_fhead[c] = link_mem.exists(c * Slots + n) ? link_mem[c * Slots + n] : 0;
    end else begin
      off = c_bump[c];
      c_bump[c] += blk;
    end
    c_live[c]++;
    if (c_fhead[c] == 0 && c_bump[c] + blk > ChunkSize) begin
      unlink_chunk(cls, c);
      c_full[c] = 1;
    end
    r.block_addr = 24'((c << ChunkLog2) + off);
    r.status = StOk;
    return r;
  endfunction

  function automatic rsp_t free_block(logic [23:0] a);
    rsp_t r;
    int unsigned c, off, blk, n;
    r = '0;
    r.status = StOk;
    if (a == 0) return r;
    c = a >> ChunkLog2;
    off = a & (ChunkSize - 1);
    r.status = StBadFree;
    if (c >= n_claimed) return r;
    blk = blk_bytes(c_cls[c]);
    if (off < HdrBytes || off >= c_bump[c] || c_live[c] == 0) return r;
    if ((off - HdrBytes) % blk != 0) return r;
    n = (off - HdrBytes) / blk + 1;
    if (n >= Slots) return r;
    link_mem[c * Slots + n] = c_fhead[c];
    c_fhead[c] = n;
    c_live[c]--;
    if (c_full[c]) begin
      push_chunk(c_cls[c], c);
      c_full[c] = 0;
    end
    r.status = StOk;
    return r;
  endfunction

  task automatic send_req(input req_t rq);
    rsp_t ex;
    int idx;
    if (!no_idle) begin
      while ($urandom_range(99) < 33) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    ex = rq.req_type ? free_block(rq.free_addr) : alloc_block(rq.req_size);
    pending_rsp.push_back(ex);
    if (ex.status == StOk && rq.req_type == ReqAlloc) live_blocks.push_back(ex.block_addr);
    if (ex.status == StOk && rq.req_type == ReqFree && rq.free_addr != 0) begin
      idx = -1;
      foreach (live_blocks[i]) if (live_blocks[i] == rq.free_addr && idx < 0) idx = i;
      if (idx >= 0) live_blocks.delete(idx);
    end
  endtask

  // directed rows; typed expectation only where obvious
  typedef struct {
    logic        rtype;
    logic [31:0] sz;
    logic [23:0] fa;
    bit          has_ex;
    rsp_t        ex;
  } row_t;

  row_t dir_rows[] = '{
    '{ReqFree,  32'd0,          24'h000000, 1, '{24'h0, StOk}},
    '{ReqFree,  32'd0,          24'hFFFFFF, 1, '{24'h0, StBadFree}},
    '{ReqAlloc, 32'hFFFFFFFF,   24'h0,      1, '{24'h0, StTooLarge}},
    '{ReqAlloc, 32'd131073,     24'hFFFFFF, 1, '{24'h0, StTooLarge}},
    '{ReqAlloc, 32'd0,          24'h0,      1, '{24'h000040, StOk}},
    '{ReqAlloc, 32'd1,          24'h0,      1, '{24'h000050, StOk}},
    '{ReqAlloc, 32'd4096,       24'h0,      0, '{24'h0, StOk}},
    '{ReqAlloc, 32'd4097,       24'h0,      0, '{24'h0, StOk}},
    '{ReqAlloc, 32'd131072,     24'h0,      0, '{24'h0, StOk}},
    '{ReqAlloc, 32'd65536,      24'h0,      0, '{24'h0, StOk}},
    '{ReqFree,  32'hFFFFFFFF,   24'h000050, 0, '{24'h0, StOk}},
    '{ReqFree,  32'd0,          24'h000050, 0, '{24'h0, StOk}},
    '{ReqFree,  32'd0,          24'h000010, 1, '{24'h0, StBadFree}},
    '{ReqFree,  32'd0,          24'h000044, 1, '{24'h0, StBadFree}},
    '{ReqFree,  32'd0,          24'h0FFFF0, 1, '{24'h0, StBadFree}},
    '{ReqAlloc, 32'd16,         24'h0,      0, '{24'h0, StOk}},
    '{ReqAlloc, 32'd16,         24'h0,      0, '{24'h0, StOk}},
    '{ReqAlloc, 32'd8192,       24'h0,      0, '{24'h0, StOk}}
  };

  initial begin
    req_t rq;
    int unsigned k;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    no_idle = 1'b0;
    n_claimed = 0;
    foreach (cls_head[i]) cls_head[i] = Nil;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      rq.req_type  = dir_rows[i].rtype;
      rq.req_size  = dir_rows[i].sz;
      rq.free_addr = dir_rows[i].fa;
      send_req(rq);
      if (dir_rows[i].has_ex && pending_rsp[$] != dir_rows[i].ex) begin
        $error("table row %0d: expected %h, model gives %h", i, dir_rows[i].ex, pending_rsp[$]);
        failed = 1'b1;
      end
    end
    // claim the whole pool with 128K blocks then overflow it
    for (int i = 0; i < 12 * 8; i++) begin
      rq = '0;
      rq.req_size = 32'd131072;
      send_req(rq);
    end
    for (int i = 0; i < 1250; i++) begin
      no_idle = (i >= 400 && i < 550);
      rq = '0;
      rq.req_type = $urandom_range(99) < 45;
      k = $urandom_range(99);
      if (k < 60) rq.req_size = $urandom_range(4096);
      else if (k < 70) rq.req_size = $urandom_range(131072, 4097);
      else if (k < 75) rq.req_size = $urandom;
      else rq.req_size = 32'd16 << $urandom_range(3);
      k = $urandom_range(99);
      if (k < 75 && live_blocks.size() > 0)
        rq.free_addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
      else if (k < 80) rq.free_addr = 24'h0;
      else rq.free_addr = 24'($urandom);
      send_req(rq);
    end
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  always @(posedge clk_i) begin
    rsp_t ex;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %h", rsp_if.data);
        failed = 1'b1;
      end else begin
        ex = pending_rsp.pop_front();
        if (rsp_if.data.block_addr !== ex.block_addr) begin
          $error("block_addr expected %h actual %h", ex.block_addr, rsp_if.data.block_addr);
          failed = 1'b1;
        end
        if (rsp_if.data.status !== ex.status) begin
          $error("status expected %0d actual %0d", ex.status, rsp_if.data.status);
          failed = 1'b1;
        end
      end
    end
    if (rst_ni) rsp_if.ready <= no_idle || ($urandom_range(99) >= 33);
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
